[rtl/core/qvr_pkg.sv]
// Shared constants and types for the quaternion vector rotation core.
package qvr_pkg;

	localparam int QUAT_WIDTH     = 16;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int VEC_WIDTH      = 24;

	// 16x16 product, matrix entry (sum of four products, or of two products doubled), matrix x vector
	localparam int PROD_W = 2 * QUAT_WIDTH;
	localparam int MAT_W  = PROD_W + 2;
	localparam int PP_W   = MAT_W + VEC_WIDTH;
	localparam int ACC_W  = PP_W + 2;
	localparam int SHIFT  = 2 * QUAT_FRAC_BITS;

	localparam int IN_BITS  = 4 * QUAT_WIDTH + 3 * VEC_WIDTH;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 3 * VEC_WIDTH;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (SHIFT - 1);
	localparam logic signed [ACC_W-1:0] VEC_MAX    = ACC_W'((64'sd1 <<< (VEC_WIDTH - 1)) - 1);
	localparam logic signed [ACC_W-1:0] VEC_MIN    = -(ACC_W'(64'sd1 <<< (VEC_WIDTH - 1)));

	typedef logic signed [QUAT_WIDTH-1:0] quat_elem_t;
	typedef logic signed [VEC_WIDTH-1:0]  vec_elem_t;
	typedef logic signed [PROD_W-1:0]     prod_elem_t;
	typedef logic signed [MAT_W-1:0]      mat_elem_t;
	typedef logic signed [PP_W-1:0]       pp_elem_t;
	typedef logic signed [ACC_W-1:0]      acc_elem_t;

	typedef struct packed {
		quat_elem_t w;
		quat_elem_t x;
		quat_elem_t y;
		quat_elem_t z;
	} quat_t;

	// element 0 is x
	typedef vec_elem_t [2:0] vec_t;

	typedef struct packed {
		prod_elem_t ww;
		prod_elem_t xx;
		prod_elem_t yy;
		prod_elem_t zz;
		prod_elem_t xy;
		prod_elem_t xz;
		prod_elem_t yz;
		prod_elem_t wx;
		prod_elem_t wy;
		prod_elem_t wz;
	} prod_t;

	// row-major, element 3*row+col
	typedef mat_elem_t [8:0] mat_t;
	typedef pp_elem_t  [8:0] pp_t;
	typedef acc_elem_t [2:0] acc_t;

endpackage

[rtl/core/quaternion_vector_rotate_core.sv]
// Top level of the fixed-point quaternion vector rotation core.
//
// Rotates a 3D vector by a quaternion: r = 2((u.v)u + w(u x v)) + (w^2 - u.u)v.
// The quaternion (Q2.14) is not normalized, so a non-unit one also scales v.
// Input channel s_axis: one request carries quat_w/x/y/z and vec_x/y/z.
// Output channel m_axis: rot_x/y/z in tdata, the saturation flag in tuser.
// Results come out in request order, one per request, rounded to nearest
// (ties up) and saturated to the vector width.
// Pipeline: s1 quadratic terms, s2 matrix entries, s3 matrix x vector
// products, s4 row sums, s5 round/saturate into the output register.
// Throughput: one request per cycle when the output side is not stalled.
// Each stage holds a valid bit and advances when it is empty or the stage
// after it advances, so a stalled receiver fills empty stages first and then
// backpressures s_axis_tready; nothing is dropped or repeated.
// Reset clears all valid bits; s_axis_tready stays low until the first clock
// after reset is released.
module quaternion_vector_rotate_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
	input  logic [qvr_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// rot_x, rot_y, rot_z
	output logic [qvr_pkg::OUT_W-1:0]   m_axis_tdata,
	// clipped
	output logic                        m_axis_tuser
);

	localparam int QW = qvr_pkg::QUAT_WIDTH;
	localparam int VW = qvr_pkg::VEC_WIDTH;

	logic          run_q;
	logic          quad_in_ready;
	logic          quad_valid, mac_ready;
	logic          mac_valid, rnd_ready;
	qvr_pkg::quat_t in_quat;
	qvr_pkg::vec_t  in_vec;
	qvr_pkg::mat_t  quad_mat;
	qvr_pkg::vec_t  quad_vec;
	qvr_pkg::acc_t  mac_acc;
	qvr_pkg::vec_t  rot;
	logic          clip;

	// hold off requests while in reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign s_axis_tready = quad_in_ready && run_q;

	// tdata unpacking, first field lowest
	assign in_quat.w = s_axis_tdata[0*QW +: QW];
	assign in_quat.x = s_axis_tdata[1*QW +: QW];
	assign in_quat.y = s_axis_tdata[2*QW +: QW];
	assign in_quat.z = s_axis_tdata[3*QW +: QW];
	assign in_vec[0] = s_axis_tdata[4*QW +: VW];
	assign in_vec[1] = s_axis_tdata[4*QW+VW +: VW];
	assign in_vec[2] = s_axis_tdata[4*QW+2*VW +: VW];

	qvr_quad u_quad (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid && run_q),
		.in_ready  (quad_in_ready),
		.in_quat   (in_quat),
		.in_vec    (in_vec),
		.out_valid (quad_valid),
		.out_ready (mac_ready),
		.out_mat   (quad_mat),
		.out_vec   (quad_vec)
	);

	qvr_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (quad_valid),
		.in_ready  (mac_ready),
		.in_mat    (quad_mat),
		.in_vec    (quad_vec),
		.out_valid (mac_valid),
		.out_ready (rnd_ready),
		.out_acc   (mac_acc)
	);

	qvr_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mac_valid),
		.in_ready  (rnd_ready),
		.in_acc    (mac_acc),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rot   (rot),
		.out_clip  (clip)
	);

	// zero fill up to whole bytes
	assign m_axis_tdata = qvr_pkg::OUT_W'({rot[2], rot[1], rot[0]});
	assign m_axis_tuser = clip;

endmodule

[rtl/core/qvr_quad.sv]
// Quadratic quaternion terms and rotation matrix, two pipeline stages.
module qvr_quad (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qvr_pkg::quat_t in_quat,
	input  qvr_pkg::vec_t  in_vec,
	output logic          out_valid,
	input  logic          out_ready,
	output qvr_pkg::mat_t  out_mat,
	output qvr_pkg::vec_t  out_vec
);

	logic           valid_s1, valid_s2;
	logic           en_s1, en_s2;
	qvr_pkg::prod_t prod_s1;
	qvr_pkg::vec_t  vec_s1, vec_s2;
	qvr_pkg::mat_t  mat_s2;
	qvr_pkg::mat_t  mat_d;

	qvr_pkg::mat_elem_t e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1.ww <= qvr_pkg::PROD_W'(in_quat.w) * qvr_pkg::PROD_W'(in_quat.w);
			prod_s1.xx <= qvr_pkg::PROD_W'(in_quat.x) * qvr_pkg::PROD_W'(in_quat.x);
			prod_s1.yy <= qvr_pkg::PROD_W'(in_quat.y) * qvr_pkg::PROD_W'(in_quat.y);
			prod_s1.zz <= qvr_pkg::PROD_W'(in_quat.z) * qvr_pkg::PROD_W'(in_quat.z);
			prod_s1.xy <= qvr_pkg::PROD_W'(in_quat.x) * qvr_pkg::PROD_W'(in_quat.y);
			prod_s1.xz <= qvr_pkg::PROD_W'(in_quat.x) * qvr_pkg::PROD_W'(in_quat.z);
			prod_s1.yz <= qvr_pkg::PROD_W'(in_quat.y) * qvr_pkg::PROD_W'(in_quat.z);
			prod_s1.wx <= qvr_pkg::PROD_W'(in_quat.w) * qvr_pkg::PROD_W'(in_quat.x);
			prod_s1.wy <= qvr_pkg::PROD_W'(in_quat.w) * qvr_pkg::PROD_W'(in_quat.y);
			prod_s1.wz <= qvr_pkg::PROD_W'(in_quat.w) * qvr_pkg::PROD_W'(in_quat.z);
			vec_s1     <= in_vec;
		end
	end

	always_comb begin
		e_ww = qvr_pkg::MAT_W'(prod_s1.ww);
		e_xx = qvr_pkg::MAT_W'(prod_s1.xx);
		e_yy = qvr_pkg::MAT_W'(prod_s1.yy);
		e_zz = qvr_pkg::MAT_W'(prod_s1.zz);
		e_xy = qvr_pkg::MAT_W'(prod_s1.xy);
		e_xz = qvr_pkg::MAT_W'(prod_s1.xz);
		e_yz = qvr_pkg::MAT_W'(prod_s1.yz);
		e_wx = qvr_pkg::MAT_W'(prod_s1.wx);
		e_wy = qvr_pkg::MAT_W'(prod_s1.wy);
		e_wz = qvr_pkg::MAT_W'(prod_s1.wz);
		mat_d[0] = e_ww + e_xx - e_yy - e_zz;
		mat_d[1] = (e_xy - e_wz) <<< 1;
		mat_d[2] = (e_xz + e_wy) <<< 1;
		mat_d[3] = (e_xy + e_wz) <<< 1;
		mat_d[4] = e_ww - e_xx + e_yy - e_zz;
		mat_d[5] = (e_yz - e_wx) <<< 1;
		mat_d[6] = (e_xz - e_wy) <<< 1;
		mat_d[7] = (e_yz + e_wx) <<< 1;
		mat_d[8] = e_ww - e_xx - e_yy + e_zz;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			mat_s2 <= mat_d;
			vec_s2 <= vec_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_mat   = mat_s2;
	assign out_vec   = vec_s2;

endmodule

[rtl/core/qvr_mac.sv]
// Matrix times vector: nine products, then row sums with rounding offset.
module qvr_mac (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qvr_pkg::mat_t  in_mat,
	input  qvr_pkg::vec_t  in_vec,
	output logic          out_valid,
	input  logic          out_ready,
	output qvr_pkg::acc_t  out_acc
);

	logic          valid_s3, valid_s4;
	logic          en_s3, en_s4;
	qvr_pkg::pp_t  pp_s3;
	qvr_pkg::acc_t acc_s4;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_valid;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s3[3*i+j] <= qvr_pkg::PP_W'(in_mat[3*i+j]) *
						qvr_pkg::PP_W'(in_vec[j]);
				end
			end
		end
	end

	// half an LSB of the output scale is folded into the row sum
	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= qvr_pkg::ACC_W'(pp_s3[3*i]) +
					qvr_pkg::ACC_W'(pp_s3[3*i+1]) +
					qvr_pkg::ACC_W'(pp_s3[3*i+2]) + qvr_pkg::ROUND_HALF;
			end
		end
	end

	assign out_valid = valid_s4;
	assign out_acc   = acc_s4;

endmodule

[rtl/core/qvr_round.sv]
// Scale down, saturate and hold the result in the output register.
module qvr_round (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  qvr_pkg::acc_t  in_acc,
	output logic          out_valid,
	input  logic          out_ready,
	output qvr_pkg::vec_t  out_rot,
	output logic          out_clip
);

	logic          valid_s5;
	logic          en_s5;
	qvr_pkg::vec_t rot_s5;
	logic          clip_s5;
	qvr_pkg::vec_t rot_d;
	logic          clip_d;
	qvr_pkg::acc_elem_t scaled;

	assign en_s5    = !valid_s5 || out_ready;
	assign in_ready = en_s5;

	always_comb begin
		clip_d = 1'b0;
		rot_d  = '0;
		scaled = '0;
		for (int i = 0; i < 3; i++) begin
			scaled = in_acc[i] >>> qvr_pkg::SHIFT;
			if (scaled > qvr_pkg::VEC_MAX) begin
				rot_d[i] = qvr_pkg::VEC_MAX[qvr_pkg::VEC_WIDTH-1:0];
				clip_d   = 1'b1;
			end else if (scaled < qvr_pkg::VEC_MIN) begin
				rot_d[i] = qvr_pkg::VEC_MIN[qvr_pkg::VEC_WIDTH-1:0];
				clip_d   = 1'b1;
			end else begin
				rot_d[i] = scaled[qvr_pkg::VEC_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en_s5) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			rot_s5  <= rot_d;
			clip_s5 <= clip_d;
		end
	end

	assign out_valid = valid_s5;
	assign out_rot   = rot_s5;
	assign out_clip  = clip_s5;

endmodule

[rtl/core/qvr_check.sv]
// Port-level checks for the rotation core, bound to the top level.
module qvr_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [qvr_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                      m_axis_tuser
);

	localparam int VW = qvr_pkg::VEC_WIDTH;
	localparam logic [VW-1:0] RMAX = qvr_pkg::VEC_MAX[VW-1:0];
	localparam logic [VW-1:0] RMIN = qvr_pkg::VEC_MIN[VW-1:0];

	logic          in_acc;
	logic [VW-1:0] rx, ry, rz;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign rx     = m_axis_tdata[0 +: VW];
	assign ry     = m_axis_tdata[VW +: VW];
	assign rz     = m_axis_tdata[2*VW +: VW];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// with the receiver ready throughout, each accepted request reaches m_axis_tvalid through stages s1 to s5
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tready, 1) && $past(m_axis_tready, 2) && $past(m_axis_tready, 3) &&
		$past(m_axis_tready, 4) && $past(m_axis_tready, 5) &&
		$past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3) &&
		$past(arst_n, 4) && $past(arst_n, 5) |->
			m_axis_tvalid == $past(in_acc, 5))
		else $error("result timing does not match requests");

	// the flag only comes with a component pinned at a rail
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			rx == RMAX || rx == RMIN || ry == RMAX || ry == RMIN ||
			rz == RMAX || rz == RMIN)
		else $error("clip flag without saturated component");

endmodule

bind quaternion_vector_rotate_core qvr_check u_qvr_check (.*);

[tb/sv/tb_quaternion_vector_rotate_core.sv]
// Self-checking stream testbench for the quaternion vector rotation core.

typedef struct {
	qvr_pkg::quat_elem_t w;
	qvr_pkg::quat_elem_t x;
	qvr_pkg::quat_elem_t y;
	qvr_pkg::quat_elem_t z;
	qvr_pkg::vec_elem_t  vx;
	qvr_pkg::vec_elem_t  vy;
	qvr_pkg::vec_elem_t  vz;
} rot_request_t;

typedef struct {
	qvr_pkg::vec_elem_t rx;
	qvr_pkg::vec_elem_t ry;
	qvr_pkg::vec_elem_t rz;
	bit                 clipped;
} rot_result_t;

// Keeps the rotated vectors still owed by the core, oldest first.
class rotation_scoreboard;
	rot_result_t rotated_q[$];
	int requests;
	int results;
	int clip_count;
	int mismatches;

	// Exact matrix form of q v q*, rounded half up at 2^(2F), saturated.
	function rot_result_t rotate(rot_request_t r);
		longint w, x, y, z, acc, q;
		longint m[3][3];
		longint v[3];
		longint vmax, vmin;
		qvr_pkg::vec_elem_t o[3];
		rot_result_t res;
		w = r.w;
		x = r.x;
		y = r.y;
		z = r.z;
		v[0] = r.vx;
		v[1] = r.vy;
		v[2] = r.vz;
		vmax = (longint'(1) <<< (qvr_pkg::VEC_WIDTH - 1)) - 1;
		vmin = -(longint'(1) <<< (qvr_pkg::VEC_WIDTH - 1));
		m[0][0] = w*w + x*x - y*y - z*z;
		m[0][1] = 2 * (x*y - w*z);
		m[0][2] = 2 * (x*z + w*y);
		m[1][0] = 2 * (x*y + w*z);
		m[1][1] = w*w - x*x + y*y - z*z;
		m[1][2] = 2 * (y*z - w*x);
		m[2][0] = 2 * (x*z - w*y);
		m[2][1] = 2 * (y*z + w*x);
		m[2][2] = w*w - x*x - y*y + z*z;
		res.clipped = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2];
			q = (acc + (longint'(1) <<< (qvr_pkg::SHIFT - 1))) >>> qvr_pkg::SHIFT;
			if (q > vmax) begin
				q = vmax;
				res.clipped = 1'b1;
			end else if (q < vmin) begin
				q = vmin;
				res.clipped = 1'b1;
			end
			o[i] = qvr_pkg::vec_elem_t'(q);
		end
		res.rx = o[0];
		res.ry = o[1];
		res.rz = o[2];
		return res;
	endfunction

	function void note_request(rot_request_t r);
		rotated_q.push_back(rotate(r));
		requests++;
	endfunction

	function void report(string what, longint want, longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endfunction

	function void check_result(logic [qvr_pkg::OUT_W-1:0] data, logic user);
		rot_result_t want;
		qvr_pkg::vec_elem_t gx, gy, gz;
		gx = data[qvr_pkg::VEC_WIDTH-1:0];
		gy = data[2*qvr_pkg::VEC_WIDTH-1:qvr_pkg::VEC_WIDTH];
		gz = data[3*qvr_pkg::VEC_WIDTH-1:2*qvr_pkg::VEC_WIDTH];
		results++;
		if (rotated_q.size() == 0) begin
			report("unexpected result rot_x", 0, gx);
			return;
		end
		want = rotated_q.pop_front();
		if (want.clipped)
			clip_count++;
		if (gx !== want.rx)
			report("rot_x", want.rx, gx);
		if (gy !== want.ry)
			report("rot_y", want.ry, gy);
		if (gz !== want.rz)
			report("rot_z", want.rz, gz);
		if (user !== want.clipped)
			report("clipped", want.clipped, user);
	endfunction

	function int pending();
		return rotated_q.size();
	endfunction
endclass

module tb_quaternion_vector_rotate_core;
	timeunit 1ns;
	timeprecision 1ps;

	import qvr_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                m_axis_tuser;

	rotation_scoreboard sb;
	bit send_idle;
	bit recv_idle;

	quaternion_vector_rotate_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic rot_request_t make_request(int w, int x, int y, int z,
			int vx, int vy, int vz);
		rot_request_t r;
		r.w  = quat_elem_t'(w);
		r.x  = quat_elem_t'(x);
		r.y  = quat_elem_t'(y);
		r.z  = quat_elem_t'(z);
		r.vx = vec_elem_t'(vx);
		r.vy = vec_elem_t'(vy);
		r.vz = vec_elem_t'(vz);
		return r;
	endfunction

	// Mix of raw bit patterns, mid-range quaternions and small-scale quaternions.
	function automatic rot_request_t random_request();
		rot_request_t r;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			r.w = quat_elem_t'($urandom());
			r.x = quat_elem_t'($urandom());
			r.y = quat_elem_t'($urandom());
			r.z = quat_elem_t'($urandom());
		end else if (kind < 8) begin
			r.w = quat_elem_t'($urandom_range(0, 23170) - 11585);
			r.x = quat_elem_t'($urandom_range(0, 23170) - 11585);
			r.y = quat_elem_t'($urandom_range(0, 23170) - 11585);
			r.z = quat_elem_t'($urandom_range(0, 23170) - 11585);
		end else begin
			r.w = quat_elem_t'($urandom_range(0, 1024) - 512);
			r.x = quat_elem_t'($urandom_range(0, 1024) - 512);
			r.y = quat_elem_t'($urandom_range(0, 1024) - 512);
			r.z = quat_elem_t'($urandom_range(0, 1024) - 512);
		end
		if ($urandom_range(0, 3) == 0) begin
			r.vx = vec_elem_t'($urandom_range(0, 2000) - 1000);
			r.vy = vec_elem_t'($urandom_range(0, 2000) - 1000);
			r.vz = vec_elem_t'($urandom_range(0, 2000) - 1000);
		end else begin
			r.vx = vec_elem_t'($urandom());
			r.vy = vec_elem_t'($urandom());
			r.vz = vec_elem_t'($urandom());
		end
		return r;
	endfunction

	// Holds one request on s_axis until the core takes it; tvalid stays up
	// into the next request when no gap is drawn.
	task automatic send_request(rot_request_t r);
		int gap;
		gap = send_idle ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.vz, r.vy, r.vx, r.z, r.y, r.x, r.w};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(r);
	endtask

	// Drops tvalid before the last accepted request can be taken again.
	task automatic wait_for_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls on m_axis_tready, every result checked.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = recv_idle ? $urandom_range(0, 16) : 0;
			@(negedge clk);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		rot_request_t directed[$];
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		send_idle     = 1'b0;
		recv_idle     = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// identity, and identity at the vector extremes
		directed.push_back(make_request(16384, 0, 0, 0, 1000, -2000, 3000));
		directed.push_back(make_request(16384, 0, 0, 0, 8388607, 8388607, 8388607));
		directed.push_back(make_request(16384, 0, 0, 0, -8388608, -8388608, -8388608));
		// quarter turn about z, half turn about x and about y
		directed.push_back(make_request(11585, 0, 0, 11585, 8388607, 0, 0));
		directed.push_back(make_request(0, 16384, 0, 0, 123456, -654321, 777777));
		directed.push_back(make_request(0, 0, -16384, 0, -8388608, 8388607, 1));
		// zero quaternion wipes the vector
		directed.push_back(make_request(0, 0, 0, 0, 8388607, -8388608, 5));
		// largest magnitudes, saturating both ways
		directed.push_back(make_request(-32768, -32768, -32768, -32768,
				8388607, 8388607, 8388607));
		directed.push_back(make_request(32767, 32767, 32767, 32767,
				-8388608, -8388608, -8388608));
		directed.push_back(make_request(-32768, 0, 0, 0, 3000000, -3000000, 0));
		directed.push_back(make_request(0, -32768, -32768, 0, 8388607, -8388608, 8388607));
		directed.push_back(make_request(32767, -32768, 32767, -32768, -1, 1, -8388608));
		// rounding ties: halves go toward plus infinity
		directed.push_back(make_request(128, 0, 0, 0, 8192, -8192, 24576));
		directed.push_back(make_request(128, 0, 0, 0, -24576, 1, -1));
		// tiny scale rounds to zero
		directed.push_back(make_request(1, 0, 0, 0, 8388607, -8388608, 4000000));
		// alternating bit patterns in every field
		directed.push_back(make_request('h5555, 'hAAAA, 'h5555, 'hAAAA,
				'h555555, 'hAAAAAA, 'h555555));
		directed.push_back(make_request('hAAAA, 'h5555, 'hAAAA, 'h5555,
				'hAAAAAA, 'h555555, 'hAAAAAA));
		// a unit quaternion with equal components, and non-unit scaling of a rotation
		directed.push_back(make_request(8192, 8192, 8192, 8192, 1048576, -2097152, 4194303));
		directed.push_back(make_request(23170, 0, 23170, 0, -4194304, 4194303, 1048576));
		foreach (directed[i])
			send_request(directed[i]);

		// nothing in flight before the random stretch
		wait_for_drain();

		for (int blk = 0; blk < 28; blk++) begin
			send_idle = $urandom_range(0, 1);
			recv_idle = $urandom_range(0, 1);
			if (blk % 5 == 4)
				wait_for_drain();
			for (int n = 0; n < 50; n++)
				send_request(random_request());
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0d rotations never came out", sb.pending());
			sb.mismatches += sb.pending();
		end

		$display("Run: %0d requests sent, %0d rotated vectors checked, %0d saturated.",
				sb.requests, sb.results, sb.clip_count);
		$display("Covered identity, half and quarter turns, ties, scaling and clipping.");
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

[quaternion_vector_rotate_core.f]
rtl/core/qvr_pkg.sv
rtl/core/qvr_quad.sv
rtl/core/qvr_mac.sv
rtl/core/qvr_round.sv
rtl/core/quaternion_vector_rotate_core.sv
rtl/core/qvr_check.sv
tb/sv/tb_quaternion_vector_rotate_core.sv
